/* src/rounded_rect_alpha_blend_unit_defines.svh */
// ----------------------------------------------------------------------------
// Rounded rectangle alpha blend unit: assertion macros
// Shared macros for the concurrent checks of the blend pipeline.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_ALPHA_BLEND_UNIT_DEFINES_SVH
`define ROUNDED_RECT_ALPHA_BLEND_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define RRAB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rrab check failed");
// Next-cycle implication, disabled while reset is asserted.
`define RRAB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rrab check failed");
`else
`define RRAB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RRAB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/rrab_pkg.sv */
// ----------------------------------------------------------------------------
// Rounded rectangle alpha blend package
// Transaction types, register map, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
package rrab_pkg;

    // Coordinate format and clipping limit.
    localparam int COORD_FRACTION_BITS = 4;
    localparam int MAX_IMAGE_SIDE      = 4096;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes.
    localparam logic [2:0] REG_RECT_LEFT     = 3'd0;
    localparam logic [2:0] REG_RECT_TOP      = 3'd1;
    localparam logic [2:0] REG_RECT_RIGHT    = 3'd2;
    localparam logic [2:0] REG_RECT_BOTTOM   = 3'd3;
    localparam logic [2:0] REG_CORNER_RADIUS = 3'd4;
    localparam logic [2:0] REG_FILL_COLOR    = 3'd5;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd6;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd7;

    // Divider widths: dividend 2N+na, divisor 2na, nine quotient bits.
    localparam int NUM_W = 26;
    localparam int DEN_W = 17;
    localparam int QUO_W = 9;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  dst_red;
        logic [7:0]  dst_green;
        logic [7:0]  dst_blue;
        logic [7:0]  dst_alpha;
        logic [7:0]  coverage;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       written;
    } pixel_out_t;

    typedef struct packed {
        logic signed [16:0] rect_left;
        logic signed [16:0] rect_top;
        logic signed [16:0] rect_right;
        logic signed [16:0] rect_bottom;
        logic [14:0]        corner_radius;
        logic [31:0]        fill_color;
        logic [12:0]        image_width;
        logic [12:0]        image_height;
    } cfg_t;

    // Floor of x/255 for any 16-bit value below 65280, without a divider.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
        return sum[15:8];
    endfunction

endpackage

/* src/rrab_geom.sv */
// ----------------------------------------------------------------------------
// Rounded rectangle coverage test
// Three-stage span clip and corner distance test for one pixel per cycle.
// ----------------------------------------------------------------------------
module rrab_geom (
    input  logic             clk,
    input  rrab_pkg::cfg_t   cfg,
    input  logic [11:0]      pixel_x,
    input  logic [11:0]      pixel_y,
    output logic             hit
);
    import rrab_pkg::*;

    localparam int CW = 20;
    localparam int DW = 21;
    localparam logic signed [CW-1:0] FRAC_MASK = CW'((1 << COORD_FRACTION_BITS) - 1);

    logic signed [CW-1:0] left_s, top_s, right_s, bottom_s;
    logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y, lo_xc, lo_yc, hi_xc, hi_yc;
    logic signed [CW-1:0] w_s, h_s, x_s, y_s, px, py, r2, cl, cr, ct, cb;
    logic [12:0]          w_lim, h_lim;
    logic signed [DW-1:0] dx, dy;
    logic                 span, corner;
    logic [31:0]          rr_reg;
    logic                 span1_reg, corner1_reg, span2_reg, corner2_reg, hit_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg;
    logic signed [2*DW-1:0] dxx2_reg, dyy2_reg;
    logic signed [2*DW:0] dist2;
    logic                 static_ok;

    // Edges in a common signed width.
    assign left_s   = CW'(cfg.rect_left);
    assign top_s    = CW'(cfg.rect_top);
    assign right_s  = CW'(cfg.rect_right);
    assign bottom_s = CW'(cfg.rect_bottom);

    // Pixel span: floor of the low edge to ceil of the high edge, clipped.
    always_comb
    begin
        lo_x  = left_s >>> COORD_FRACTION_BITS;
        lo_y  = top_s >>> COORD_FRACTION_BITS;
        hi_x  = (right_s + FRAC_MASK) >>> COORD_FRACTION_BITS;
        hi_y  = (bottom_s + FRAC_MASK) >>> COORD_FRACTION_BITS;
        w_lim = (cfg.image_width > 13'(MAX_IMAGE_SIDE)) ? 13'(MAX_IMAGE_SIDE)
                                                        : cfg.image_width;
        h_lim = (cfg.image_height > 13'(MAX_IMAGE_SIDE)) ? 13'(MAX_IMAGE_SIDE)
                                                         : cfg.image_height;
        w_s   = signed'(CW'(w_lim));
        h_s   = signed'(CW'(h_lim));
        lo_xc = (lo_x < 0) ? '0 : lo_x;
        lo_yc = (lo_y < 0) ? '0 : lo_y;
        hi_xc = (hi_x > w_s - 1) ? w_s - 1 : hi_x;
        hi_yc = (hi_y > h_s - 1) ? h_s - 1 : hi_y;
        x_s   = signed'(CW'(pixel_x));
        y_s   = signed'(CW'(pixel_y));
        span  = (x_s >= lo_xc) && (x_s <= hi_xc) && (y_s >= lo_yc) && (y_s <= hi_yc);
    end

    // Corner selection in half-step units, tried in the fixed corner order.
    always_comb
    begin
        px = signed'(CW'({pixel_x, 1'b1}) << COORD_FRACTION_BITS);
        py = signed'(CW'({pixel_y, 1'b1}) << COORD_FRACTION_BITS);
        r2 = signed'(CW'({cfg.corner_radius, 1'b0}));
        cl = (left_s <<< 1) + r2;
        cr = (right_s <<< 1) - r2;
        ct = (top_s <<< 1) + r2;
        cb = (bottom_s <<< 1) - r2;
        corner = 1'b1;
        dx = DW'(px) - DW'(cl);
        dy = DW'(py) - DW'(ct);
        if ((px < cl) && (py < ct))
        begin
            dx = DW'(px) - DW'(cl);
            dy = DW'(py) - DW'(ct);
        end
        else if ((px > cr) && (py < ct))
        begin
            dx = DW'(px) - DW'(cr);
            dy = DW'(py) - DW'(ct);
        end
        else if ((px < cl) && (py > cb))
        begin
            dx = DW'(px) - DW'(cl);
            dy = DW'(py) - DW'(cb);
        end
        else if ((px > cr) && (py > cb))
        begin
            dx = DW'(px) - DW'(cr);
            dy = DW'(py) - DW'(cb);
        end
        else
        begin
            corner = 1'b0;
        end
        if (cfg.corner_radius == '0)
        begin
            corner = 1'b0;
        end
    end

    // Squared radius follows the radius register.
    always_ff @(posedge clk)
    begin
        rr_reg <= {cfg.corner_radius, 1'b0} * {cfg.corner_radius, 1'b0};
    end

    // Stage one: span flag and corner offsets.
    always_ff @(posedge clk)
    begin
        span1_reg   <= span;
        corner1_reg <= corner;
        dx1_reg     <= dx;
        dy1_reg     <= dy;
    end

    // Stage two: squares.
    always_ff @(posedge clk)
    begin
        span2_reg   <= span1_reg;
        corner2_reg <= corner1_reg;
        dxx2_reg    <= dx1_reg * dx1_reg;
        dyy2_reg    <= dy1_reg * dy1_reg;
    end

    // Stage three: distance compare and whole-rectangle conditions.
    assign dist2     = (2*DW+1)'(dxx2_reg) + (2*DW+1)'(dyy2_reg);
    assign static_ok = (cfg.rect_right > cfg.rect_left) && (cfg.rect_bottom > cfg.rect_top)
                       && (cfg.fill_color[7:0] != 8'd0);

    always_ff @(posedge clk)
    begin
        hit_reg <= static_ok && span2_reg &&
                   (!corner2_reg || (dist2 <= signed'((2*DW+1)'(rr_reg))));
    end

    assign hit = hit_reg;

endmodule

/* src/rrab_mix.sv */
// ----------------------------------------------------------------------------
// Rounded rectangle blend arithmetic
// Five-stage pipeline forming effective alpha, result alpha and the per
// channel dividend and divisor of the source-over blend.
// ----------------------------------------------------------------------------
module rrab_mix (
    input  logic                                clk,
    input  rrab_pkg::pixel_in_t                 pixel,
    input  logic [31:0]                         fill_color,
    output logic [2:0][rrab_pkg::NUM_W-1:0]     num,
    output logic [rrab_pkg::DEN_W-1:0]          den,
    output logic [7:0]                          alpha,
    output logic                                alpha_nz
);
    import rrab_pkg::*;

    logic [2:0][7:0]  src;
    logic [15:0]      p1_reg;
    logic [7:0]       da1_reg, da2_reg, a2_reg, a3_reg;
    logic [2:0][7:0]  d1_reg, d2_reg, d3_reg;
    logic [15:0]      t3_reg, na4_reg;
    logic [2:0][23:0] dt4_reg;
    logic [2:0][15:0] sa4_reg;
    logic             anz4_reg;
    logic [2:0][NUM_W-1:0] num5_reg;
    logic [DEN_W-1:0] den5_reg;
    logic [7:0]       alpha5_reg;
    logic             anz5_reg;
    logic [2:0][23:0] n_sum;

    // Red in lane two, then green, blue in lane zero.
    assign src = fill_color[31:8];

    // Stage one: coverage times fill alpha.
    always_ff @(posedge clk)
    begin
        p1_reg  <= pixel.coverage * fill_color[7:0];
        da1_reg <= pixel.dst_alpha;
        d1_reg  <= {pixel.dst_red, pixel.dst_green, pixel.dst_blue};
    end

    // Stage two: effective alpha.
    always_ff @(posedge clk)
    begin
        a2_reg  <= div255(p1_reg);
        da2_reg <= da1_reg;
        d2_reg  <= d1_reg;
    end

    // Stage three: destination weight.
    always_ff @(posedge clk)
    begin
        t3_reg <= da2_reg * (8'd255 - a2_reg);
        a3_reg <= a2_reg;
        d3_reg <= d2_reg;
    end

    // Stage four: result alpha numerator and channel products.
    always_ff @(posedge clk)
    begin
        na4_reg  <= ({8'd0, a3_reg} << 8) - {8'd0, a3_reg} + t3_reg;
        anz4_reg <= (a3_reg != 8'd0);
        for (int c = 0; c < 3; c++)
        begin
            dt4_reg[c] <= 24'(d3_reg[c]) * 24'(t3_reg);
            sa4_reg[c] <= 16'(src[c]) * 16'(a3_reg);
        end
    end

    // Stage five: dividends, divisor and rounded result alpha.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            n_sum[c] = (24'(sa4_reg[c]) << 8) - 24'(sa4_reg[c]) + dt4_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            num5_reg[c] <= {1'b0, n_sum[c], 1'b0} + NUM_W'(na4_reg);
        end
        den5_reg   <= {na4_reg, 1'b0};
        alpha5_reg <= div255(na4_reg + 16'd127);
        anz5_reg   <= anz4_reg;
    end

    assign num      = num5_reg;
    assign den      = den5_reg;
    assign alpha    = alpha5_reg;
    assign alpha_nz = anz5_reg;

endmodule

/* src/rrab_div.sv */
// ----------------------------------------------------------------------------
// Rounded rectangle blend divider
// Three-stage restoring divider, three quotient bits per stage.
// ----------------------------------------------------------------------------
module rrab_div (
    input  logic                          clk,
    input  logic [rrab_pkg::NUM_W-1:0]    num,
    input  logic [rrab_pkg::DEN_W-1:0]    den,
    output logic [rrab_pkg::QUO_W-1:0]    quo
);
    import rrab_pkg::*;

    localparam int STAGES = 3;
    localparam int BITS   = QUO_W / STAGES;

    logic [NUM_W-1:0] rem_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic [QUO_W-1:0] q_reg   [STAGES];
    logic [NUM_W-1:0] rem_in  [STAGES];
    logic [DEN_W-1:0] den_in  [STAGES];
    logic [QUO_W-1:0] q_in    [STAGES];
    logic [NUM_W-1:0] rem_out [STAGES];
    logic [QUO_W-1:0] q_out   [STAGES];

    assign rem_in[0] = num;
    assign den_in[0] = den;
    assign q_in[0]   = '0;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        if (s > 0)
        begin : g_link
            assign rem_in[s] = rem_reg[s-1];
            assign den_in[s] = den_reg[s-1];
            assign q_in[s]   = q_reg[s-1];
        end

        // Trial subtraction of the shifted divisor, most significant bit first.
        always_comb
        begin
            logic [NUM_W:0] trial;
            logic [NUM_W-1:0] rem;
            logic [QUO_W-1:0] q;
            rem = rem_in[s];
            q   = q_in[s];
            for (int j = 0; j < BITS; j++)
            begin
                trial = {1'b0, rem} - ((NUM_W+1)'(den_in[s]) << (QUO_W - 1 - s*BITS - j));
                if (!trial[NUM_W])
                begin
                    rem = trial[NUM_W-1:0];
                    q[QUO_W - 1 - s*BITS - j] = 1'b1;
                end
            end
            rem_out[s] = rem;
            q_out[s]   = q;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_out[s];
            den_reg[s] <= den_in[s];
            q_reg[s]   <= q_out[s];
        end
    end

    assign quo = q_reg[STAGES-1];

endmodule

/* src/rounded_rect_alpha_blend_unit.sv */
// A pixel's result strobe passes the valid shift register, then the result valid register.
// Throughput: one pixel per cycle; busy is always low and the pipeline never stalls.
// Depth is set by the 5-stage blend arithmetic plus the 3-stage divider and output register.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// Reset clears the pipeline valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
// Rounded rectangle alpha blend unit
// Source-over fill of a clipped rounded rectangle, one pixel per clock.
// ----------------------------------------------------------------------------
`include "rounded_rect_alpha_blend_unit_defines.svh"
module rounded_rect_alpha_blend_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rrab_pkg::pixel_in_t           in,
    output logic                          result_valid,
    output rrab_pkg::pixel_out_t          result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrab_pkg::ADDR_W-1:0]   paddr,
    input  logic [rrab_pkg::DATA_W-1:0]   pwdata,
    output logic [rrab_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import rrab_pkg::*;

    localparam int PIPE_LAT = 8;
    localparam int GEOM_LAT = 3;
    localparam int MIX_LAT  = 5;

    cfg_t                  cfg_reg;
    logic [2:0]            reg_idx;
    logic                  cfg_write;
    logic                  accept;
    logic [PIPE_LAT-1:0]   valid_reg;
    pixel_in_t             pix_reg [PIPE_LAT];
    logic [PIPE_LAT-GEOM_LAT-1:0] hit_reg;
    logic [PIPE_LAT-MIX_LAT-1:0]  anz_reg;
    logic [7:0]            alpha_reg [PIPE_LAT-MIX_LAT];
    logic                  geom_hit;
    logic [2:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]      den;
    logic [7:0]            mix_alpha;
    logic                  mix_anz;
    logic [2:0][QUO_W-1:0] quo;
    logic [2:0][7:0]       chan;
    logic                  blend;
    logic                  result_valid_reg;
    pixel_out_t            result_reg;
    pixel_in_t             pass;

    // Handshakes.
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_RECT_LEFT:     cfg_reg.rect_left     <= signed'(pwdata[16:0]);
                REG_RECT_TOP:      cfg_reg.rect_top      <= signed'(pwdata[16:0]);
                REG_RECT_RIGHT:    cfg_reg.rect_right    <= signed'(pwdata[16:0]);
                REG_RECT_BOTTOM:   cfg_reg.rect_bottom   <= signed'(pwdata[16:0]);
                REG_CORNER_RADIUS: cfg_reg.corner_radius <= pwdata[14:0];
                REG_FILL_COLOR:    cfg_reg.fill_color    <= pwdata;
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[12:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= pwdata[12:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_RECT_LEFT:     prdata = DATA_W'(cfg_reg.rect_left);
            REG_RECT_TOP:      prdata = DATA_W'(cfg_reg.rect_top);
            REG_RECT_RIGHT:    prdata = DATA_W'(cfg_reg.rect_right);
            REG_RECT_BOTTOM:   prdata = DATA_W'(cfg_reg.rect_bottom);
            REG_CORNER_RADIUS: prdata = DATA_W'(cfg_reg.corner_radius);
            REG_FILL_COLOR:    prdata = cfg_reg.fill_color;
            REG_IMAGE_WIDTH:   prdata = DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:  prdata = DATA_W'(cfg_reg.image_height);
            default:           prdata = '0;
        endcase
    end

    // Coverage test, blend arithmetic and one divider per colour channel.
    rrab_geom u_geom (
        .clk     (clk),
        .cfg     (cfg_reg),
        .pixel_x (in.pixel_x),
        .pixel_y (in.pixel_y),
        .hit     (geom_hit)
    );

    rrab_mix u_mix (
        .clk        (clk),
        .pixel      (in),
        .fill_color (cfg_reg.fill_color),
        .num        (num),
        .den        (den),
        .alpha      (mix_alpha),
        .alpha_nz   (mix_anz)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        rrab_div u_div (
            .clk (clk),
            .num (num[c]),
            .den (den),
            .quo (quo[c])
        );
        assign chan[c] = (quo[c] > QUO_W'(255)) ? 8'd255 : quo[c][7:0];
    end

    // Valid bits travel with each transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg        <= {valid_reg[PIPE_LAT-2:0], accept};
            result_valid_reg <= valid_reg[PIPE_LAT-1];
        end
    end

    // Destination bytes and side results delayed to meet the divider output.
    always_ff @(posedge clk)
    begin
        pix_reg[0] <= in;
        for (int i = 1; i < PIPE_LAT; i++)
        begin
            pix_reg[i] <= pix_reg[i-1];
        end
        hit_reg      <= {hit_reg[PIPE_LAT-GEOM_LAT-2:0], geom_hit};
        anz_reg      <= {anz_reg[PIPE_LAT-MIX_LAT-2:0], mix_anz};
        alpha_reg[0] <= mix_alpha;
        for (int i = 1; i < PIPE_LAT - MIX_LAT; i++)
        begin
            alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    // Output register: blended pixel or the destination unchanged.
    assign pass  = pix_reg[PIPE_LAT-1];
    assign blend = hit_reg[PIPE_LAT-GEOM_LAT-1] && anz_reg[PIPE_LAT-MIX_LAT-1];

    always_ff @(posedge clk)
    begin
        if (blend)
        begin
            result_reg <= {chan[2], chan[1], chan[0], alpha_reg[PIPE_LAT-MIX_LAT-1], 1'b1};
        end
        else
        begin
            result_reg <= {pass.dst_red, pass.dst_green, pass.dst_blue, pass.dst_alpha, 1'b0};
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Every accepted transaction yields its result after the fixed latency.
    `RRAB_ASSERT_IMP(a_latency, clk, rst_n, accept, ##(PIPE_LAT+1) result_valid)
    // A blended pixel never ends fully transparent.
    `RRAB_ASSERT_IMP(a_blend_alpha, clk, rst_n, result_valid && result.written, result.out_alpha != 8'd0)
    // A pass-through result carries the destination bytes of its own transaction.
    `RRAB_ASSERT_NXT(a_pass_data, clk, rst_n, valid_reg[PIPE_LAT-1] && !blend, result.out_red == $past(pass.dst_red) && result.out_alpha == $past(pass.dst_alpha))

endmodule

/* verif/rounded_rect_alpha_blend_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rounded rectangle alpha blend unit testbench
// Drives pixel transactions through the blend unit under a series of register
// settings, predicts every result with an independent model of the clipping,
// corner and source-over arithmetic, and checks each result field by field.
// ----------------------------------------------------------------------------
module rounded_rect_alpha_blend_unit_tb;

    import rrab_pkg::*;

    localparam int  RESULT_LATENCY = 9;
    localparam longint CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    pixel_in_t            in;
    logic                 result_valid;
    pixel_out_t           result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // Shadow copy of the configuration registers.
    longint rect_l, rect_t, rect_r, rect_b, radius, img_w, img_h;
    logic [31:0] fill;

    pixel_out_t expected_pixels[$];
    int     error_count;
    int     pixels_sent;
    int     pixels_blended;
    int     pixels_checked;
    longint cycle_count;
    bit     idle_enable;

    rounded_rect_alpha_blend_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in           (in),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Floor and ceiling of a sixteenth-pixel coordinate.
    function automatic longint floor_pixel(longint v);
        return v >>> COORD_FRACTION_BITS;
    endfunction

    function automatic longint ceil_pixel(longint v);
        return -((-v) >>> COORD_FRACTION_BITS);
    endfunction

    function automatic bit within_radius(longint dx, longint dy, longint r);
        return dx * dx + dy * dy <= r * r;
    endfunction

    // Whether a pixel lies in the clipped rounded rectangle.
    function automatic bit covers_pixel(longint x, longint y);
        longint lo_x, lo_y, hi_x, hi_y, w, h;
        longint px, py, r, cl, cr, ct, cb;
        lo_x = floor_pixel(rect_l);
        lo_y = floor_pixel(rect_t);
        hi_x = ceil_pixel(rect_r);
        hi_y = ceil_pixel(rect_b);
        w = (img_w > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : img_w;
        h = (img_h > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : img_h;
        if (lo_x < 0) lo_x = 0;
        if (lo_y < 0) lo_y = 0;
        if (hi_x > w - 1) hi_x = w - 1;
        if (hi_y > h - 1) hi_y = h - 1;
        if (x < lo_x || x > hi_x || y < lo_y || y > hi_y)
            return 1'b0;
        if (radius == 0)
            return 1'b1;
        // Work in half-sixteenths so that the pixel centre is an integer.
        px = (2 * x + 1) <<< COORD_FRACTION_BITS;
        py = (2 * y + 1) <<< COORD_FRACTION_BITS;
        r  = 2 * radius;
        cl = 2 * rect_l + r;
        cr = 2 * rect_r - r;
        ct = 2 * rect_t + r;
        cb = 2 * rect_b - r;
        if (px < cl && py < ct) return within_radius(px - cl, py - ct, r);
        if (px > cr && py < ct) return within_radius(px - cr, py - ct, r);
        if (px < cl && py > cb) return within_radius(px - cl, py - cb, r);
        if (px > cr && py > cb) return within_radius(px - cr, py - cb, r);
        return 1'b1;
    endfunction

    function automatic logic [7:0] mix_channel(longint s, longint d, longint a,
                                               longint da, longint na);
        longint n, v;
        n = 255 * s * a + d * da * (255 - a);
        v = (2 * n + na) / (2 * na);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Expected result of one pixel under the current register settings.
    function automatic pixel_out_t blend_pixel(pixel_in_t p);
        pixel_out_t o;
        longint fa, a, da, na;
        fa = fill[7:0];
        a  = (longint'(p.coverage) * fa) / 255;
        da = p.dst_alpha;
        o = '{p.dst_red, p.dst_green, p.dst_blue, p.dst_alpha, 1'b0};
        if (rect_r > rect_l && rect_b > rect_t && fa != 0 && a != 0 &&
            covers_pixel(p.pixel_x, p.pixel_y))
        begin
            na = 255 * a + da * (255 - a);
            o.out_red   = mix_channel(fill[31:24], p.dst_red, a, da, na);
            o.out_green = mix_channel(fill[23:16], p.dst_green, a, da, na);
            o.out_blue  = mix_channel(fill[15:8], p.dst_blue, a, da, na);
            o.out_alpha = 8'((na + 127) / 255);
            o.written   = 1'b1;
        end
        return o;
    endfunction

    // Result checker: every strobe is compared with the oldest expectation.
    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && result_valid)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (result.out_red !== want.out_red)
                begin
                    $display("%0t: out_red expected %0d actual %0d", $time,
                             want.out_red, result.out_red);
                    error_count++;
                end
                if (result.out_green !== want.out_green)
                begin
                    $display("%0t: out_green expected %0d actual %0d", $time,
                             want.out_green, result.out_green);
                    error_count++;
                end
                if (result.out_blue !== want.out_blue)
                begin
                    $display("%0t: out_blue expected %0d actual %0d", $time,
                             want.out_blue, result.out_blue);
                    error_count++;
                end
                if (result.out_alpha !== want.out_alpha)
                begin
                    $display("%0t: out_alpha expected %0d actual %0d", $time,
                             want.out_alpha, result.out_alpha);
                    error_count++;
                end
                if (result.written !== want.written)
                begin
                    $display("%0t: written expected %0d actual %0d", $time,
                             want.written, result.written);
                    error_count++;
                end
            end
        end
    end

    // Write one register over the configuration port and mirror it.
    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RECT_LEFT:     rect_l = longint'($signed(value[16:0]));
            REG_RECT_TOP:      rect_t = longint'($signed(value[16:0]));
            REG_RECT_RIGHT:    rect_r = longint'($signed(value[16:0]));
            REG_RECT_BOTTOM:   rect_b = longint'($signed(value[16:0]));
            REG_CORNER_RADIUS: radius = value[14:0];
            REG_FILL_COLOR:    fill   = value;
            REG_IMAGE_WIDTH:   img_w  = value[12:0];
            REG_IMAGE_HEIGHT:  img_h  = value[12:0];
            default: ;
        endcase
    endtask

    task automatic configure(longint l, longint t, longint r, longint b, longint rad,
                             logic [31:0] colour, longint w, longint h);
        write_register(REG_RECT_LEFT, 32'(l));
        write_register(REG_RECT_TOP, 32'(t));
        write_register(REG_RECT_RIGHT, 32'(r));
        write_register(REG_RECT_BOTTOM, 32'(b));
        write_register(REG_CORNER_RADIUS, 32'(rad));
        write_register(REG_FILL_COLOR, colour);
        write_register(REG_IMAGE_WIDTH, 32'(w));
        write_register(REG_IMAGE_HEIGHT, 32'(h));
    endtask

    // Wait until every expected result has arrived and the pipeline is empty.
    task automatic drain;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 3) @(posedge clk);
    endtask

    // Send one pixel transaction and record its expected result.
    task automatic send_pixel(pixel_in_t p);
        pixel_out_t want;
        start <= 1'b1;
        in    <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want = blend_pixel(p);
        expected_pixels = {expected_pixels, want};
        pixels_sent++;
        if (want.written)
            pixels_blended++;
        if (idle_enable && $urandom_range(99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_fields(longint x, longint y, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic [7:0] a, logic [7:0] cov);
        pixel_in_t p;
        p = '{12'(x), 12'(y), r, g, b, a, cov};
        send_pixel(p);
    endtask

    function automatic longint clip_coord(longint v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    // Random pixels, mostly close to the rectangle, some anywhere at all.
    task automatic random_pixels(int count);
        pixel_in_t p;
        longint lo_x, hi_x, lo_y, hi_y;
        lo_x = clip_coord(floor_pixel(rect_l) - 3);
        hi_x = clip_coord(ceil_pixel(rect_r) + 3);
        lo_y = clip_coord(floor_pixel(rect_t) - 3);
        hi_y = clip_coord(ceil_pixel(rect_b) + 3);
        if (hi_x < lo_x) hi_x = lo_x;
        if (hi_y < lo_y) hi_y = lo_y;
        for (int i = 0; i < count; i++)
        begin
            p = pixel_in_t'({$urandom, $urandom});
            if ($urandom_range(99) < 85)
            begin
                p.pixel_x = 12'($urandom_range(hi_x, lo_x));
                p.pixel_y = 12'($urandom_range(hi_y, lo_y));
            end
            if ($urandom_range(9) == 0)
                p.coverage = 8'd255;
            send_pixel(p);
        end
        start <= 1'b0;
    endtask

    // Random rounded rectangle inside a small image, some edges off the image.
    task automatic random_settings;
        longint l, t, w, h;
        logic [31:0] colour;
        l = longint'($urandom_range(800)) - 160;
        t = longint'($urandom_range(800)) - 160;
        w = $urandom_range(16, 64);
        h = $urandom_range(16, 64);
        colour = $urandom;
        if ($urandom_range(9) == 0)
            colour[7:0] = 8'd0;
        configure(l, t, l + $urandom_range(800), t + $urandom_range(800),
                  ($urandom_range(3) == 0) ? 0 : $urandom_range(320), colour, w, h);
    endtask

    // Registers at reset value: an empty rectangle, everything passes through.
    task automatic test_reset_values;
        send_fields(0, 0, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF);
        send_fields(4095, 4095, 8'h12, 8'h34, 8'h56, 8'h78, 8'h80);
        start <= 1'b0;
        drain();
    endtask

    // Directed corners of the field ranges and of the geometry.
    task automatic test_directed;
        // Plain rectangle filling a whole full-size image.
        configure(-65536, -65536, 65535, 65535, 0, 32'hFF8040FF, 4096, 4096);
        send_fields(0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_fields(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_fields(2048, 17, 8'h10, 8'h20, 8'h30, 8'h00, 8'h01);
        send_fields(5, 4095, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00);
        start <= 1'b0;
        drain();
        // Oversized image sides saturate; transparent fill passes through.
        configure(-16, -16, 65535, 65535, 32767, 32'h00000000, 8191, 8191);
        send_fields(4095, 0, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF);
        start <= 1'b0;
        drain();
        write_register(REG_FILL_COLOR, 32'hFFFFFFFF);
        send_fields(4095, 4095, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF);
        send_fields(0, 0, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF);
        start <= 1'b0;
        drain();
        // Rounded corners on a small rectangle with fractional edges.
        configure(37, 21, 300, 250, 80, 32'h40C0E080, 32, 32);
        send_fields(2, 1, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF);
        send_fields(3, 2, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF);
        send_fields(18, 1, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF);
        send_fields(2, 15, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF);
        send_fields(18, 15, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hFF);
        send_fields(10, 8, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hC0);
        send_fields(19, 8, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF);
        send_fields(1, 8, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF);
        start <= 1'b0;
        drain();
        // Empty rectangle and an image of zero width.
        configure(400, 16, 400, 300, 0, 32'hFFFFFFFF, 64, 64);
        send_fields(25, 5, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF);
        start <= 1'b0;
        drain();
        configure(0, 0, 400, 400, 0, 32'hFFFFFFFF, 0, 64);
        send_fields(0, 5, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF);
        start <= 1'b0;
        drain();
    endtask

    // Random phases under changing settings, one of them with no idling.
    task automatic test_random_phases;
        for (int phase = 0; phase < 10; phase++)
        begin
            idle_enable = (phase != 4);
            random_settings();
            random_pixels(80);
            drain();
        end
        idle_enable = 1'b1;
    endtask

    // Oversized radius and full-range edges with random pixels.
    task automatic test_extreme_settings;
        configure(-65536, 0, 520, 65535, 32767, $urandom | 32'h1, 40, 8191);
        random_pixels(25);
        drain();
        configure(8, 8, 480, 400, 32767, $urandom | 32'h1, 33, 30);
        random_pixels(25);
        drain();
    endtask

    // The sender holds off until every result is back, then carries on.
    task automatic test_pause_until_empty;
        random_settings();
        random_pixels(20);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        random_pixels(20);
        drain();
    endtask

    // Stimulus sequence.
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        in          = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        error_count = 0;
        pixels_sent = 0;
        pixels_blended = 0;
        pixels_checked = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        rect_l = 0; rect_t = 0; rect_r = 0; rect_b = 0;
        radius = 0; img_w = 0; img_h = 0; fill = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_random_phases();
        test_extreme_settings();
        test_pause_until_empty();
        drain();

        $display("Sent %0d pixels over 20 register settings, %0d blended, %0d checked.",
                 pixels_sent, pixels_blended, pixels_checked);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
